// File: hw/rtl/lrast_pkg.sv
// Shared constants for the line rasteriser.
package lrast_pkg;

  localparam int COORD_BITS_DEFAULT = 12;
  localparam int WIDTH_BITS         = 12;
  localparam int ADDR_BITS          = 24;
  localparam int BPP_BITS           = 2;
  localparam int STRIDE_BITS        = WIDTH_BITS + BPP_BITS;

  localparam logic [WIDTH_BITS-1:0] WIDTH_RESET     = WIDTH_BITS'(512);
  localparam logic [BPP_BITS-1:0]   BYTES_PER_PIXEL = BPP_BITS'(3);

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_STEP  = 1'b1;

endpackage

// File: hw/rtl/line_rasterizer.sv
// Bresenham line rasteriser with clipping and RGB byte address output.
//
//   channel | signals                                           | direction
//   --------+---------------------------------------------------+----------
//   cfg     | cfg_we, cfg_data (image width)                    | in
//   in      | in_valid, in_stall, mode, start_x/y, end_x/y      | in
//   out     | out_valid, out_stall, drawn, pixel_x/y, on_image, | out
//           | byte_address, last                                |
//
// One pixel per cycle while out_stall is low. Each transaction passes a
// stepping stage (Bresenham iteration and clipping) and then an address
// stage (one multiply, one add), each ending in a register. Synchronous reset
// returns the block to idle with image width 512. A stall on the output holds
// both stages and backs up onto in_stall; the input side keeps taking
// transactions while either stage has room.
module line_rasterizer
  import lrast_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [WIDTH_BITS-1:0]        cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         mode,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         drawn,
  output logic signed [COORD_BITS-1:0] pixel_x,
  output logic signed [COORD_BITS-1:0] pixel_y,
  output logic                         on_image,
  output logic [ADDR_BITS-1:0]         byte_address,
  output logic                         last
);

  localparam int D_W   = COORD_BITS + 1;
  localparam int ERR_W = COORD_BITS + 3;
  localparam int E2_W  = ERR_W + 1;
  localparam int CMP_W = (COORD_BITS > WIDTH_BITS) ? COORD_BITS : WIDTH_BITS;

  // Line state
  logic                         active;
  logic signed [COORD_BITS-1:0] cur_x, cur_y, target_x, target_y;
  logic signed [D_W-1:0]        delta_x, neg_delta_y;
  logic [1:0]                   step_signs;
  logic signed [ERR_W-1:0]      error_term;

  // Configuration
  logic [WIDTH_BITS-1:0]  image_width;
  logic [STRIDE_BITS-1:0] row_stride;

  // Stepping stage output
  logic                         a_valid;
  logic                         a_drawn, a_keep, a_last;
  logic signed [COORD_BITS-1:0] a_x, a_y;
  logic [ADDR_BITS-1:0]         a_x3;

  logic in_accept, b_take;

  // Combinational stepping
  logic                         is_start, emit;
  logic signed [COORD_BITS-1:0] sx, sy, tx, ty;
  logic signed [D_W-1:0]        ddx, ddy, dx, ndy;
  logic [1:0]                   signs;
  logic signed [ERR_W-1:0]      err, err_next;
  logic signed [E2_W-1:0]       e2;
  logic signed [COORD_BITS-1:0] x_next, y_next;
  logic                         keep, at_end;
  logic [CMP_W-1:0]             x_cmp;
  logic [ADDR_BITS-1:0]         x_u;

  assign b_take    = !out_valid || !out_stall;
  assign in_stall  = a_valid && !b_take;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    is_start = (mode == MODE_START);
    emit     = is_start || active;
    if (is_start) begin
      sx    = start_x;
      sy    = start_y;
      tx    = end_x;
      ty    = end_y;
      ddx   = D_W'(end_x) - D_W'(start_x);
      ddy   = D_W'(end_y) - D_W'(start_y);
      dx    = ddx[D_W-1] ? -ddx : ddx;
      ndy   = ddy[D_W-1] ? ddy : -ddy;
      signs = {start_y < end_y, start_x < end_x};
      err   = ERR_W'(dx) + ERR_W'(ndy);
    end else begin
      sx    = cur_x;
      sy    = cur_y;
      tx    = target_x;
      ty    = target_y;
      ddx   = '0;
      ddy   = '0;
      dx    = delta_x;
      ndy   = neg_delta_y;
      signs = step_signs;
      err   = error_term;
    end

    at_end = (sx == tx) && (sy == ty);
    x_cmp  = CMP_W'($unsigned(sx));
    keep   = !sx[COORD_BITS-1] && !sy[COORD_BITS-1] && (x_cmp < CMP_W'(image_width));
    x_u    = ADDR_BITS'($unsigned(sx));

    e2       = E2_W'(err) <<< 1;
    err_next = err;
    x_next   = sx;
    y_next   = sy;
    if (e2 >= E2_W'(ndy)) begin
      err_next = err_next + ERR_W'(ndy);
      x_next   = signs[0] ? sx + COORD_BITS'(1) : sx - COORD_BITS'(1);
    end
    if (e2 <= E2_W'(dx)) begin
      err_next = err_next + ERR_W'(dx);
      y_next   = signs[1] ? sy + COORD_BITS'(1) : sy - COORD_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= WIDTH_RESET;
      row_stride  <= STRIDE_BITS'(WIDTH_RESET) * STRIDE_BITS'(BYTES_PER_PIXEL);
    end else if (cfg_we) begin
      image_width <= cfg_data;
      row_stride  <= STRIDE_BITS'(cfg_data) * STRIDE_BITS'(BYTES_PER_PIXEL);
    end
  end

  // Line state and stepping stage
  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      cur_x       <= '0;
      cur_y       <= '0;
      target_x    <= '0;
      target_y    <= '0;
      delta_x     <= '0;
      neg_delta_y <= '0;
      step_signs  <= '0;
      error_term  <= '0;
      a_valid     <= 1'b0;
    end else begin
      if (in_accept) begin
        a_valid <= 1'b1;
        if (emit) begin
          if (is_start) begin
            target_x    <= tx;
            target_y    <= ty;
            delta_x     <= dx;
            neg_delta_y <= ndy;
            step_signs  <= signs;
          end
          active <= !at_end;
          if (at_end) begin
            cur_x      <= sx;
            cur_y      <= sy;
            error_term <= err;
          end else begin
            cur_x      <= x_next;
            cur_y      <= y_next;
            error_term <= err_next;
          end
        end
      end else if (b_take) begin
        a_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      a_drawn <= emit;
      a_x     <= emit ? sx : '0;
      a_y     <= emit ? sy : '0;
      a_keep  <= emit && keep;
      a_last  <= emit && at_end;
      a_x3    <= (emit && keep) ? ADDR_BITS'(x_u + (x_u << 1)) : '0;
    end
  end

  // Address stage and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_take) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_take && a_valid) begin
      drawn    <= a_drawn;
      pixel_x  <= a_x;
      pixel_y  <= a_y;
      on_image <= a_keep;
      last     <= a_last;
      if (a_keep) begin
        byte_address <= ADDR_BITS'(ADDR_BITS'(ADDR_BITS'($unsigned(a_y)) * row_stride) + a_x3);
      end else begin
        byte_address <= '0;
      end
    end
  end

endmodule

// File: tb/line_rasterizer_test.sv
// Self-checking testbench for the Bresenham line rasteriser: directed and random lines.
module line_rasterizer_test;
  import lrast_pkg::*;

  localparam int CB = COORD_BITS_DEFAULT;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic          mode;
    logic [CB-1:0] sx;
    logic [CB-1:0] sy;
    logic [CB-1:0] ex;
    logic [CB-1:0] ey;
  } line_req_t;

  typedef struct packed {
    logic                 drawn;
    logic [CB-1:0]        px;
    logic [CB-1:0]        py;
    logic                 on_image;
    logic [ADDR_BITS-1:0] addr;
    logic                 last;
  } pixel_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [WIDTH_BITS-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  mode = MODE_START;
  logic signed [CB-1:0]  start_x = '0;
  logic signed [CB-1:0]  start_y = '0;
  logic signed [CB-1:0]  end_x = '0;
  logic signed [CB-1:0]  end_y = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  drawn;
  logic signed [CB-1:0]  pixel_x;
  logic signed [CB-1:0]  pixel_y;
  logic                  on_image;
  logic [ADDR_BITS-1:0]  byte_address;
  logic                  last;

  line_req_t pending_lines[$];
  pixel_t    expected_pixels[$];
  line_req_t next_req;
  pixel_t    want, got;

  int items_queued = 0;
  int items_taken = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  int hold_left = 0;
  bit squeezed = 1'b0;
  logic calm;

  // rasteriser state as seen by the checker
  int frame_width = 512;
  int pos_x = 0, pos_y = 0, goal_x = 0, goal_y = 0;
  int run_x = 0, rise_neg = 0, err_acc = 0;
  bit step_x_up = 1'b0, step_y_up = 1'b0;
  bit tracing = 1'b0;

  line_rasterizer dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .drawn(drawn), .pixel_x(pixel_x), .pixel_y(pixel_y), .on_image(on_image),
    .byte_address(byte_address), .last(last)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  assign calm = (items_taken >= 400) && (items_taken < 550);

  function automatic pixel_t trace_step(input line_req_t r);
    pixel_t p;
    int dx, dy, e2;
    longint a;
    p = '0;
    if (r.mode == MODE_START) begin
      pos_x = int'($signed(r.sx));
      pos_y = int'($signed(r.sy));
      goal_x = int'($signed(r.ex));
      goal_y = int'($signed(r.ey));
      dx = goal_x - pos_x;
      dy = goal_y - pos_y;
      run_x = (dx < 0) ? -dx : dx;
      rise_neg = (dy < 0) ? dy : -dy;
      step_x_up = pos_x < goal_x;
      step_y_up = pos_y < goal_y;
      err_acc = run_x + rise_neg;
      tracing = 1'b1;
    end
    if (!tracing) return p;
    p.drawn = 1'b1;
    p.px = CB'(pos_x);
    p.py = CB'(pos_y);
    p.on_image = !(pos_x < 0 || pos_y < 0 || pos_x >= frame_width);
    if (p.on_image) begin
      a = (longint'(pos_y) * frame_width + pos_x) * 3;
      p.addr = ADDR_BITS'(a);
    end
    p.last = (pos_x == goal_x) && (pos_y == goal_y);
    if (p.last) begin
      tracing = 1'b0;
    end else begin
      e2 = 2 * err_acc;
      if (e2 >= rise_neg) begin
        err_acc += rise_neg;
        pos_x += step_x_up ? 1 : -1;
      end
      if (e2 <= run_x) begin
        err_acc += run_x;
        pos_y += step_y_up ? 1 : -1;
      end
    end
    return p;
  endfunction

  function automatic int clamp_coord(input int v);
    return (v < -2048) ? -2048 : (v > 2047) ? 2047 : v;
  endfunction

  // driver: hold a stalled transaction, otherwise offer the next one or idle
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_lines.size() != 0 && (calm || $urandom_range(99) >= 18)) begin
        next_req = pending_lines.pop_front();
        in_valid <= 1'b1;
        mode <= next_req.mode;
        start_x <= next_req.sx;
        start_y <= next_req.sy;
        end_x <= next_req.ex;
        end_y <= next_req.ey;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off to back the block up
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (!squeezed && items_taken >= 150) begin
      squeezed <= 1'b1;
      hold_left <= 300;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 18);
    end
  end

  // monitor: check each result, then predict from each accepted transaction
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we)
        frame_width = int'(cfg_data);
      if (out_valid && !out_stall) begin
        got = {drawn, pixel_x, pixel_y, on_image, byte_address, last};
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: unexpected pixel drawn=%0d x=%0d y=%0d on=%0d addr=%h last=%0d",
                     got.drawn, $signed(got.px), $signed(got.py), got.on_image, got.addr,
                     got.last);
        end else begin
          want = expected_pixels.pop_front();
          if (got.drawn !== want.drawn || got.px !== want.px || got.py !== want.py ||
              got.on_image !== want.on_image || got.addr !== want.addr ||
              got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $write("mismatch: expected drawn=%0d x=%0d y=%0d on=%0d addr=%h last=%0d,",
                     want.drawn, $signed(want.px), $signed(want.py), want.on_image,
                     want.addr, want.last);
              $display(" got drawn=%0d x=%0d y=%0d on=%0d addr=%h last=%0d",
                       got.drawn, $signed(got.px), $signed(got.py), got.on_image,
                       got.addr, got.last);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_pixels.push_back(trace_step({mode, start_x, start_y, end_x, end_y}));
        items_taken <= items_taken + 1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[line_rasterizer] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_item(input line_req_t r);
    pending_lines.push_back(r);
    items_queued++;
  endtask

  task automatic queue_steps(input int n);
    line_req_t r;
    repeat (n) begin
      r = {MODE_STEP, CB'($urandom), CB'($urandom), CB'($urandom), CB'($urandom)};
      queue_item(r);
    end
  endtask

  task automatic queue_line(input int x0, input int y0, input int x1, input int y1,
                            input int steps);
    queue_item({MODE_START, CB'(x0), CB'(y0), CB'(x1), CB'(y1)});
    queue_steps(steps);
  endtask

  task automatic queue_random_lines(input int budget, input int w);
    int first, pick, span, x0, y0, x1, y1, dx, dy, len, steps;
    first = items_queued;
    while (items_queued - first < budget) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        queue_item({1'($urandom), CB'($urandom), CB'($urandom), CB'($urandom),
                    CB'($urandom)});
      end else begin
        span = (pick < 20) ? 60 : 10;
        if (pick < 30) begin
          x0 = int'($urandom_range(4095)) - 2048;
          y0 = int'($urandom_range(4095)) - 2048;
        end else begin
          x0 = clamp_coord(int'($urandom_range(w + 16)) - 8);
          y0 = int'($urandom_range(80)) - 8;
        end
        x1 = clamp_coord(x0 + int'($urandom_range(2 * span)) - span);
        y1 = clamp_coord(y0 + int'($urandom_range(2 * span)) - span);
        dx = (x1 > x0) ? x1 - x0 : x0 - x1;
        dy = (y1 > y0) ? y1 - y0 : y0 - y1;
        len = (dx > dy) ? dx : dy;
        pick = $urandom_range(99);
        if (pick < 70)
          steps = len;
        else if (pick < 85)
          steps = len + int'($urandom_range(3, 1));
        else
          steps = int'($urandom_range(len));
        queue_line(x0, y0, x1, y1, steps);
      end
    end
  endtask

  // wait for every transaction to drain, then let the pipeline empty
  task automatic settle();
    while (items_taken != items_queued || expected_pixels.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_width(input int w);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= WIDTH_BITS'(w);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    int widths[6];
    widths = '{1, 2048, 4095, 2047, 0, 0};
    widths[4] = int'($urandom_range(2047, 1));
    widths[5] = int'($urandom_range(700, 16));
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    queue_steps(1);
    queue_line(0, 0, 0, 0, 1);
    queue_line(-2048, -2048, 2047, 2047, 3);
    queue_line(2047, 2047, -2048, -2048, 2);
    queue_line(0, 0, 5, 2, 5);
    queue_line(2, 4, 1, 0, 4);
    queue_line(510, -1, 513, 1, 3);
    settle();

    foreach (widths[i]) begin
      write_width(widths[i]);
      queue_random_lines(120, widths[i]);
      settle();
    end

    if (mismatches == 0)
      $display("[line_rasterizer] OK");
    else
      $display("[line_rasterizer] ERROR");
    $finish;
  end

endmodule
